// File: hw/rtl/hed_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and reference tables for the HTML entity decoder.
// No dependencies; imported by hed_ctrl, hed_datapath and the top level.
package hed_pkg;

  localparam int HOLD_DEPTH_DEF = 16;

  // Reference match phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_AMP  = 2'd1;
  localparam logic [1:0] PH_NUM  = 2'd2;
  localparam logic [1:0] PH_NAME = 2'd3;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [7:0] VALUE_CAP = 8'd128;

  localparam int NAMED_COUNT = 7;
  localparam int NAMED_MAX   = 6;

  // Named references, lower case, '&' first; unused tail positions are zero
  localparam logic [7:0] NAMED_PAT [NAMED_COUNT][NAMED_MAX] = '{
    '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},  // &lt;
    '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},  // &gt;
    '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},  // &amp;
    '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},  // &quot;
    '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00},  // &#39;
    '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},  // &apos;
    '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}   // &nbsp;
  };
  localparam logic [2:0] NAMED_LEN [NAMED_COUNT] = '{3'd4, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd6};
  localparam logic [7:0] NAMED_VAL [NAMED_COUNT] = '{
    8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h27, 8'h20
  };

  // Controller to datapath
  typedef struct packed {
    logic capture;    // register the accepted input beat
    logic apply;      // commit decision, update match state, latch plan
    logic rd;         // read held byte at flush index
    logic push_held;  // load output register from held read data
    logic push_now;   // load output register from the live decision
    logic push_tail;  // load output register from the latched tail byte
    logic rearm;      // write '&' into slot 0 after a flush
  } hed_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eval_flush;  // decision needs held bytes flushed
    logic eval_tail;   // decision emits a single byte after any flush
    logic plan_tail;
    logic plan_rearm;
    logic flush_last;  // flush index is at the last held byte
    logic out_free;    // output register can take a beat
  } hed_sts_t;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    lower_ascii = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

// File: hw/rtl/html_entity_decoder.sv
`timescale 1ns / 1ps
// Top level of the HTML entity decoder: stream ports, controller and datapath.
// Depends on hed_pkg, hed_ctrl and hed_datapath.

// Decodes HTML character references in a byte stream, one text byte per input
// beat. Recognised: &lt; &gt; &amp; &quot; &#39; &apos; &nbsp; (letters in any
// case, &nbsp; gives a space) and numeric &#DDD; / &#xHHH; with values 1..127.
// From '&' on, bytes are held back while they can still form a reference; a
// failed reference releases them unchanged, and the text end (tlast on the
// input) flushes whatever is still held. Each input beat gives zero to
// HOLD_DEPTH+1 output beats; m_axis_tlast marks the last beat caused by one
// input beat and m_axis_tuser the last beat of the whole text. An input beat is
// accepted, then evaluated; a beat that ends in a single byte places it in the
// output register in the evaluate cycle if the register is free, and else in
// a tail step once it frees up. A flush reads each held byte through the
// single registered read port of the hold buffer and then loads it into the
// output register; after the flushed bytes comes the single byte that
// follows them, or a re-arm of the buffer when a new '&' ends the failed
// reference; a flush of a still open reference at the text end adds neither.
// The input is not taken while a beat is being worked on. Output stalls hold
// the result in the output register. No clearing pass is needed after reset:
// the hold buffer is only read below its fill count.
module html_entity_decoder
  import hed_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF  // hold buffer depth, 8..64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
  input  logic       s_axis_tlast,   // text_end
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] plain_byte
  output logic       m_axis_tlast,   // run_last
  output logic       m_axis_tuser    // [0] text_done
);

  hed_cmd_t cmd;
  hed_sts_t sts;

  // Controller: accepts a beat, then walks evaluate / flush / tail / re-arm
  hed_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: match state, hold buffer and output register
  hed_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (s_axis_tdata),
    .text_end_i   (s_axis_tlast),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .plain_byte_o (m_axis_tdata),
    .run_last_o   (m_axis_tlast),
    .text_done_o  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/hed_ctrl.sv
`timescale 1ns / 1ps
// Sequencing FSM for the HTML entity decoder.
// Depends on hed_pkg for the command and status structs.
module hed_ctrl
  import hed_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hed_sts_t sts_i,
  output hed_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EVAL      = 3'd1;
  localparam logic [2:0] S_FLUSH_RD  = 3'd2;
  localparam logic [2:0] S_FLUSH_OUT = 3'd3;
  localparam logic [2:0] S_TAIL      = 3'd4;
  localparam logic [2:0] S_REARM     = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.apply = 1'b1;
        if (sts_i.eval_flush) begin
          state_d = S_FLUSH_RD;
        end else if (sts_i.eval_tail) begin
          if (sts_i.out_free) begin
            cmd_o.push_now = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_TAIL;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FLUSH_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_FLUSH_OUT;
      end
      S_FLUSH_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.push_held = 1'b1;
          if (!sts_i.flush_last) begin
            state_d = S_FLUSH_RD;
          end else if (sts_i.plan_tail) begin
            state_d = S_TAIL;
          end else if (sts_i.plan_rearm) begin
            state_d = S_REARM;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_TAIL: begin
        if (sts_i.out_free) begin
          cmd_o.push_tail = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_REARM: begin
        cmd_o.rearm = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/hed_datapath.sv
`timescale 1ns / 1ps
// Datapath of the HTML entity decoder: match state, hold buffer, decision
// logic and output register. Depends on hed_pkg.
module hed_datapath
  import hed_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       text_end_i,
  input  hed_cmd_t   cmd_i,
  output hed_sts_t   sts_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] plain_byte_o,
  output logic       run_last_o,
  output logic       text_done_o
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  // Input beat
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Match state
  logic [1:0]             phase_q, phase_d;
  logic [CW-1:0]          held_cnt_q, held_cnt_d;
  logic [NAMED_COUNT-1:0] name_mask_q, name_mask_d;
  logic [7:0]             ref_value_q, ref_value_d;
  logic                   ref_hex_q, ref_hex_d;
  logic                   ref_digit_q, ref_digit_d;

  // Plan for the current beat
  logic [CW-1:0] flush_n_q;
  logic [CW-1:0] idx_q;
  logic          plan_tail_q;
  logic          plan_rearm_q;
  logic [7:0]    tail_byte_q;

  // Hold buffer
  logic [7:0]    held_mem [HOLD_DEPTH];
  logic [7:0]    rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_done_q;

  // Decision
  logic [7:0]             lc;
  logic                   is_open;
  logic                   is_amp;
  logic [NAMED_COUNT-1:0] nm_hit;
  logic [NAMED_COUNT-1:0] nm_full;
  logic                   done_name;
  logic [7:0]             name_val;
  logic                   is_x;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [11:0]            ref_prod;
  logic [7:0]             ref_next;
  logic                   semi_ok;
  logic                   num_ok;
  logic                   done;
  logic [7:0]             done_val;
  logic                   extend;
  logic                   fail;
  logic                   start_ref;
  logic [CW-1:0]          dec_flush_n;
  logic                   dec_tail;
  logic [7:0]             dec_tail_byte;
  logic                   write_now;

  assign lc      = lower_ascii(in_byte_q);
  assign is_open = (phase_q != PH_IDLE);
  assign is_amp  = (in_byte_q == CH_AMP);

  // Named references: mask keeps the patterns whose prefix matches the held bytes
  always_comb begin
    nm_hit   = '0;
    nm_full  = '0;
    name_val = '0;
    for (int k = 0; k < NAMED_COUNT; k++) begin
      if (is_open && name_mask_q[k] && (held_cnt_q < CW'(NAMED_LEN[k]))) begin
        nm_hit[k] = (lc == NAMED_PAT[k][held_cnt_q[2:0]]);
      end
      nm_full[k] = nm_hit[k] && ((held_cnt_q + CW'(1)) == CW'(NAMED_LEN[k]));
      if (nm_full[k]) begin
        name_val = name_val | NAMED_VAL[k];
      end
    end
  end
  assign done_name = |nm_full;

  // Numeric references
  always_comb begin
    is_digit = 1'b0;
    digit    = '0;
    if (in_byte_q >= 8'h30 && in_byte_q <= 8'h39) begin
      is_digit = 1'b1;
      digit    = in_byte_q[3:0];
    end else if (ref_hex_q && lc >= 8'h61 && lc <= 8'h66) begin
      is_digit = 1'b1;
      digit    = 4'(lc - 8'h57);
    end
  end

  assign is_x = (held_cnt_q == CW'(2)) && !ref_hex_q
                && (in_byte_q == CH_LOW_X || in_byte_q == CH_UP_X);

  assign ref_prod = ref_hex_q
                  ? ({ref_value_q, 4'b0} + 12'(digit))
                  : ({1'b0, ref_value_q, 3'b0} + {3'b0, ref_value_q, 1'b0} + 12'(digit));

  always_comb begin
    if (ref_value_q >= VALUE_CAP) begin
      ref_next = ref_value_q;
    end else if (ref_prod >= 12'(VALUE_CAP)) begin
      ref_next = VALUE_CAP;
    end else begin
      ref_next = ref_prod[7:0];
    end
  end

  assign semi_ok = (phase_q == PH_NUM) && !is_x && !is_digit && (in_byte_q == CH_SEMI)
                   && ref_digit_q && (ref_value_q != 8'd0) && (ref_value_q < VALUE_CAP);

  assign num_ok = ((phase_q == PH_AMP) && (in_byte_q == CH_HASH))
                || ((phase_q == PH_NUM) && (is_x || is_digit));

  assign done     = done_name || semi_ok;
  assign done_val = done_name ? name_val : ref_value_q;
  assign extend   = is_open && !done && ((|nm_hit) || num_ok)
                    && (held_cnt_q < CW'(HOLD_DEPTH));
  assign fail     = is_open && !done && !extend;

  // A fresh '&' opens a reference unless the text ends on it
  assign start_ref = (!is_open || fail) && is_amp && !in_end_q;

  always_comb begin
    dec_flush_n = '0;
    if (extend && in_end_q) begin
      dec_flush_n = held_cnt_q + CW'(1);
    end else if (fail) begin
      dec_flush_n = held_cnt_q;
    end
  end

  assign dec_tail      = done || ((!is_open || fail) && !start_ref);
  assign dec_tail_byte = done ? done_val : in_byte_q;
  assign write_now     = (!is_open && start_ref) || extend;

  // Next match state
  always_comb begin
    phase_d     = phase_q;
    held_cnt_d  = held_cnt_q;
    name_mask_d = name_mask_q;
    ref_value_d = ref_value_q;
    ref_hex_d   = ref_hex_q;
    ref_digit_d = ref_digit_q;
    if (cmd_i.apply) begin
      if (start_ref) begin
        phase_d     = PH_AMP;
        held_cnt_d  = CW'(1);
        name_mask_d = '1;
        ref_value_d = '0;
        ref_hex_d   = 1'b0;
        ref_digit_d = 1'b0;
      end else if (extend && !in_end_q) begin
        phase_d     = num_ok ? PH_NUM : PH_NAME;
        held_cnt_d  = held_cnt_q + CW'(1);
        name_mask_d = nm_hit & ~nm_full;
        if (num_ok) begin
          ref_value_d = is_digit ? ref_next : ref_value_q;
          ref_hex_d   = ref_hex_q | is_x;
          ref_digit_d = ref_digit_q | is_digit;
        end
      end else begin
        phase_d     = PH_IDLE;
        held_cnt_d  = '0;
        name_mask_d = '0;
        ref_value_d = '0;
        ref_hex_d   = 1'b0;
        ref_digit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      held_cnt_q   <= '0;
      name_mask_q  <= '0;
      ref_value_q  <= '0;
      ref_hex_q    <= 1'b0;
      ref_digit_q  <= 1'b0;
      in_end_q     <= 1'b0;
      flush_n_q    <= '0;
      idx_q        <= '0;
      plan_tail_q  <= 1'b0;
      plan_rearm_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      held_cnt_q  <= held_cnt_d;
      name_mask_q <= name_mask_d;
      ref_value_q <= ref_value_d;
      ref_hex_q   <= ref_hex_d;
      ref_digit_q <= ref_digit_d;
      if (cmd_i.capture) begin
        in_end_q <= text_end_i;
      end
      if (cmd_i.apply) begin
        flush_n_q    <= dec_flush_n;
        idx_q        <= '0;
        plan_tail_q  <= dec_tail;
        // rearm only follows a flush; without one slot 0 is written now
        plan_rearm_q <= fail && start_ref;
      end else if (cmd_i.push_held) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_byte_q <= text_byte_i;
    end
    if (cmd_i.apply) begin
      tail_byte_q <= dec_tail_byte;
    end
  end

  // Hold buffer: one write port, one registered read port
  assign mem_we = (cmd_i.apply && write_now && !fail) || cmd_i.rearm;
  assign mem_wa = cmd_i.rearm ? '0 : held_cnt_q[AW-1:0];
  assign mem_wd = cmd_i.rearm ? CH_AMP : in_byte_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      held_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd) begin
      rd_data_q <= held_mem[idx_q[AW-1:0]];
    end
  end

  // Output register
  logic out_load;
  assign out_load = cmd_i.push_held || cmd_i.push_now || cmd_i.push_tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_held) begin
      out_byte_q <= rd_data_q;
      out_last_q <= sts_o.flush_last && !plan_tail_q;
      out_done_q <= sts_o.flush_last && !plan_tail_q && in_end_q;
    end else if (cmd_i.push_now) begin
      out_byte_q <= dec_tail_byte;
      out_last_q <= 1'b1;
      out_done_q <= in_end_q;
    end else if (cmd_i.push_tail) begin
      out_byte_q <= tail_byte_q;
      out_last_q <= 1'b1;
      out_done_q <= in_end_q;
    end
  end

  assign sts_o.eval_flush = (dec_flush_n != '0);
  assign sts_o.eval_tail  = dec_tail;
  assign sts_o.plan_tail  = plan_tail_q;
  assign sts_o.plan_rearm = plan_rearm_q;
  assign sts_o.flush_last = (({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, flush_n_q});
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = out_byte_q;
  assign run_last_o   = out_last_q;
  assign text_done_o  = out_done_q;

endmodule

// File: hw/rtl/hed_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the HTML entity decoder, bound to the top level.
// Depends only on the ports of html_entity_decoder.
module hed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // A stalled output beat holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // One input beat in work at a time
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken in the cycle after a beat");

  // End of text is always the last beat of its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("text_done without run_last");

endmodule

bind html_entity_decoder hed_checker u_hed_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
